>>> src/ttnw_pkg.sv
// shared types and constants of the text to tile name writer
package ttnw_pkg;

  localparam int unsigned ROW_TILES = 32;
  localparam int unsigned ADDR_W    = 14;
  localparam int unsigned TILE_W    = 8;
  localparam int unsigned FONT_W    = 18;
  localparam int unsigned NUM_FONTS = 4;
  localparam int unsigned PADDR_W   = 5;
  localparam int unsigned PDATA_W   = 32;

  localparam logic [ADDR_W-1:0] NAMES_BASE_RST = 14'd6144;
  localparam logic [TILE_W-1:0] WIDE_OFFSET    = 8'd32;

  // character codes
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_SYM_FIRST = 8'h21;
  localparam logic [7:0] CH_SYM_LAST  = 8'h2f;
  localparam logic [7:0] CH_DIG_FIRST = 8'h30;
  localparam logic [7:0] CH_DIG_LAST  = 8'h39;
  localparam logic [7:0] CH_UPP_FIRST = 8'h41;
  localparam logic [7:0] CH_UPP_LAST  = 8'h5a;
  localparam logic [7:0] CH_LOW_FIRST = 8'h61;
  localparam logic [7:0] CH_LOW_LAST  = 8'h7a;

  typedef enum logic [1:0] {
    SHAPE_1X1  = 2'd0,
    SHAPE_1X2  = 2'd1,
    SHAPE_2X2  = 2'd2,
    SHAPE_NONE = 2'd3
  } shape_e;

  typedef enum logic [1:0] {
    FONT_NUMERIC = 2'd0,
    FONT_UPPER   = 2'd1,
    FONT_LOWER   = 2'd2,
    FONT_SYMBOL  = 2'd3
  } font_sel_e;

  typedef enum logic [2:0] {
    REG_NAMES_BASE   = 3'd0,
    REG_NUMERIC_FONT = 3'd1,
    REG_UPPER_FONT   = 3'd2,
    REG_LOWER_FONT   = 3'd3,
    REG_SYMBOL_FONT  = 3'd4
  } reg_idx_e;

  localparam logic CMD_SET_CURSOR = 1'b0;
  localparam logic CMD_PRINT      = 1'b1;

  typedef struct packed {
    logic       command;
    logic [4:0] column;
    logic [4:0] row;
    logic [7:0] char_code;
  } in_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] vram_addr;
    logic [TILE_W-1:0] tile_index;
    logic              last;
  } out_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]                   names_base;
    logic [NUM_FONTS-1:0][FONT_W-1:0]    fonts;
  } cfg_t;

  // one glyph as handed from the front to the back
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [TILE_W-1:0] base;
    logic [TILE_W-1:0] setw;
    shape_e            shape;
  } job_t;

endpackage

>>> src/ttnw_front.sv
// front end: classifies characters, tracks the cursor and builds glyph jobs
module ttnw_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ttnw_pkg::cfg_t    cfg_i,
  input  logic              in_valid_i,
  input  ttnw_pkg::in_req_t in_req_i,
  input  logic              q_full_i,
  output logic              in_stall_o,
  output logic              push_o,
  output ttnw_pkg::job_t    job_o
);

  logic [ttnw_pkg::ADDR_W-1:0] cursor_q, cursor_d;
  logic                        accept;
  logic                        is_glyph;
  logic                        is_space;
  ttnw_pkg::font_sel_e         font_sel;
  logic [7:0]                  glyph_idx;
  logic [ttnw_pkg::FONT_W-1:0] font;
  logic [ttnw_pkg::TILE_W-1:0] first_tile;
  logic [ttnw_pkg::TILE_W-1:0] wide_c;
  logic [ttnw_pkg::TILE_W-1:0] base_narrow;
  logic [ttnw_pkg::TILE_W-1:0] base_wide;
  ttnw_pkg::shape_e            shape;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;

  always_comb begin
    is_glyph  = 1'b0;
    is_space  = 1'b0;
    font_sel  = ttnw_pkg::FONT_NUMERIC;
    glyph_idx = '0;
    if (in_req_i.char_code == ttnw_pkg::CH_SPACE) begin
      is_space = 1'b1;
    end else if (in_req_i.char_code >= ttnw_pkg::CH_DIG_FIRST &&
                 in_req_i.char_code <= ttnw_pkg::CH_DIG_LAST) begin
      is_glyph  = 1'b1;
      font_sel  = ttnw_pkg::FONT_NUMERIC;
      glyph_idx = in_req_i.char_code - ttnw_pkg::CH_DIG_FIRST;
    end else if (in_req_i.char_code >= ttnw_pkg::CH_UPP_FIRST &&
                 in_req_i.char_code <= ttnw_pkg::CH_UPP_LAST) begin
      is_glyph  = 1'b1;
      font_sel  = ttnw_pkg::FONT_UPPER;
      glyph_idx = in_req_i.char_code - ttnw_pkg::CH_UPP_FIRST;
    end else if (in_req_i.char_code >= ttnw_pkg::CH_LOW_FIRST &&
                 in_req_i.char_code <= ttnw_pkg::CH_LOW_LAST) begin
      is_glyph  = 1'b1;
      font_sel  = ttnw_pkg::FONT_LOWER;
      glyph_idx = in_req_i.char_code - ttnw_pkg::CH_LOW_FIRST;
    end else if (in_req_i.char_code >= ttnw_pkg::CH_SYM_FIRST &&
                 in_req_i.char_code <= ttnw_pkg::CH_SYM_LAST) begin
      is_glyph  = 1'b1;
      font_sel  = ttnw_pkg::FONT_SYMBOL;
      glyph_idx = in_req_i.char_code - ttnw_pkg::CH_SYM_FIRST;
    end
  end

  assign font       = cfg_i.fonts[font_sel];
  assign first_tile = font[7:0];
  assign shape      = ttnw_pkg::shape_e'(font[17:16]);

  // wide glyphs step two tiles per character and skip a tile row past offset 32
  assign wide_c      = {glyph_idx[6:0], 1'b0};
  assign base_narrow = first_tile + glyph_idx;
  assign base_wide   = first_tile + wide_c +
                       ((wide_c > ttnw_pkg::WIDE_OFFSET) ? ttnw_pkg::WIDE_OFFSET : '0);

  always_comb begin
    job_o.addr  = cursor_q;
    job_o.base  = (shape == ttnw_pkg::SHAPE_2X2) ? base_wide : base_narrow;
    job_o.setw  = font[15:8];
    job_o.shape = shape;
  end

  assign push_o = accept && in_req_i.command == ttnw_pkg::CMD_PRINT && is_glyph &&
                  shape != ttnw_pkg::SHAPE_NONE;

  always_comb begin
    cursor_d = cursor_q;
    if (accept) begin
      if (in_req_i.command == ttnw_pkg::CMD_SET_CURSOR) begin
        cursor_d = cfg_i.names_base +
                   ttnw_pkg::ADDR_W'(in_req_i.row) *
                   ttnw_pkg::ADDR_W'(ttnw_pkg::ROW_TILES) +
                   ttnw_pkg::ADDR_W'(in_req_i.column);
      end else if (is_space) begin
        cursor_d = cursor_q + ttnw_pkg::ADDR_W'(1);
      end else if (is_glyph) begin
        cursor_d = cursor_q + ((shape == ttnw_pkg::SHAPE_2X2) ?
                               ttnw_pkg::ADDR_W'(2) : ttnw_pkg::ADDR_W'(1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
    end else begin
      cursor_q <= cursor_d;
    end
  end

endmodule

>>> src/ttnw_queue.sv
// short job queue between front and back
module ttnw_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ttnw_pkg::job_t push_job_i,
  input  logic           pop_i,
  output ttnw_pkg::job_t head_o,
  output logic           empty_o,
  output logic           full_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ttnw_pkg::job_t   mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

>>> src/ttnw_back.sv
// back end: expands a glyph job into one name table write per cycle while the output is not stalled
module ttnw_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ttnw_pkg::job_t     head_i,
  input  logic               q_empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ttnw_pkg::out_req_t out_req_o
);

  logic               act_q, act_d;
  ttnw_pkg::job_t     job_q, job_d;
  logic [1:0]         step_q, step_d;
  logic               out_valid_q, out_valid_d;
  ttnw_pkg::out_req_t out_q, out_d;
  logic               out_ready;
  logic               row_sel, col_sel, fin;

  assign out_ready = ~out_valid_q | ~out_stall_i;

  // position of this step inside the glyph
  always_comb begin
    row_sel = 1'b0;
    col_sel = 1'b0;
    fin     = 1'b1;
    case (job_q.shape)
      ttnw_pkg::SHAPE_1X2: begin
        row_sel = step_q[0];
        fin     = (step_q == 2'd1);
      end
      ttnw_pkg::SHAPE_2X2: begin
        row_sel = step_q[1];
        col_sel = step_q[0];
        fin     = (step_q == 2'd3);
      end
      default: begin
        fin = 1'b1;
      end
    endcase
  end

  always_comb begin
    act_d       = act_q;
    job_d       = job_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    pop_o       = 1'b0;
    if (out_ready) begin
      out_valid_d = act_q;
      if (act_q) begin
        out_d.vram_addr  = job_q.addr +
                           (row_sel ? ttnw_pkg::ADDR_W'(ttnw_pkg::ROW_TILES) : '0) +
                           ttnw_pkg::ADDR_W'(col_sel);
        out_d.tile_index = job_q.base + (row_sel ? job_q.setw : '0) +
                           ttnw_pkg::TILE_W'(col_sel);
        out_d.last       = fin;
        step_d           = step_q + 2'd1;
        if (fin) begin
          act_d  = 1'b0;
          step_d = '0;
        end
      end
    end
    // take the next job once the current one has issued its final write
    if ((!act_q || (out_ready && fin)) && !q_empty_i) begin
      pop_o  = 1'b1;
      act_d  = 1'b1;
      job_d  = head_i;
      step_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q       <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      act_q       <= act_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

>>> src/text_to_tile_name_writer.sv
// a glyph's writes pass from the queue via the job register to the output register
// throughput: one request per cycle while the job queue has room; the back end
// issues one write per cycle unless stalled; a 2x2 glyph gives four writes
// cursor, space and ignored requests give no write
// reset: registers return to their reset values, cursor to 0, queue and output empty
module text_to_tile_name_writer #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  ttnw_pkg::in_req_t                in_req_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output ttnw_pkg::out_req_t               out_req_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ttnw_pkg::PADDR_W-1:0]     paddr,
  input  logic [ttnw_pkg::PDATA_W-1:0]     pwdata,
  output logic [ttnw_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready
);

  ttnw_pkg::cfg_t     cfg_q;
  ttnw_pkg::reg_idx_e reg_idx;
  logic               cfg_we;
  logic               push;
  logic               pop;
  logic               q_full;
  logic               q_empty;
  ttnw_pkg::job_t     push_job;
  ttnw_pkg::job_t     head_job;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign reg_idx = ttnw_pkg::reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.names_base <= ttnw_pkg::NAMES_BASE_RST;
      cfg_q.fonts      <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx)
        ttnw_pkg::REG_NAMES_BASE:   cfg_q.names_base <= pwdata[ttnw_pkg::ADDR_W-1:0];
        ttnw_pkg::REG_NUMERIC_FONT: cfg_q.fonts[ttnw_pkg::FONT_NUMERIC] <=
                                      pwdata[ttnw_pkg::FONT_W-1:0];
        ttnw_pkg::REG_UPPER_FONT:   cfg_q.fonts[ttnw_pkg::FONT_UPPER] <=
                                      pwdata[ttnw_pkg::FONT_W-1:0];
        ttnw_pkg::REG_LOWER_FONT:   cfg_q.fonts[ttnw_pkg::FONT_LOWER] <=
                                      pwdata[ttnw_pkg::FONT_W-1:0];
        ttnw_pkg::REG_SYMBOL_FONT:  cfg_q.fonts[ttnw_pkg::FONT_SYMBOL] <=
                                      pwdata[ttnw_pkg::FONT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ttnw_pkg::REG_NAMES_BASE:   prdata = ttnw_pkg::PDATA_W'(cfg_q.names_base);
      ttnw_pkg::REG_NUMERIC_FONT: prdata =
                                    ttnw_pkg::PDATA_W'(cfg_q.fonts[ttnw_pkg::FONT_NUMERIC]);
      ttnw_pkg::REG_UPPER_FONT:   prdata =
                                    ttnw_pkg::PDATA_W'(cfg_q.fonts[ttnw_pkg::FONT_UPPER]);
      ttnw_pkg::REG_LOWER_FONT:   prdata =
                                    ttnw_pkg::PDATA_W'(cfg_q.fonts[ttnw_pkg::FONT_LOWER]);
      ttnw_pkg::REG_SYMBOL_FONT:  prdata =
                                    ttnw_pkg::PDATA_W'(cfg_q.fonts[ttnw_pkg::FONT_SYMBOL]);
      default:                    prdata = '0;
    endcase
  end

  ttnw_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_req_i   (in_req_i),
    .q_full_i   (q_full),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .job_o      (push_job)
  );

  ttnw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (pop),
    .head_o     (head_job),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  ttnw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_job),
    .q_empty_i   (q_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

endmodule

>>> dv/tb_text_to_tile_name_writer.sv
// self-checking testbench for the text to tile name writer
module tb_text_to_tile_name_writer;
  import ttnw_pkg::*;

  localparam int unsigned IN_REQ_W = $bits(in_req_t);

  class name_write_board;
    logic [ADDR_W-1:0] names_base;
    logic [FONT_W-1:0] fonts [NUM_FONTS];
    logic [ADDR_W-1:0] cursor;
    out_req_t          pending_writes [$];
    int                errors;

    function new();
      names_base = NAMES_BASE_RST;
      foreach (fonts[i]) fonts[i] = '0;
      cursor = '0;
      errors = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [PDATA_W-1:0] value);
      case (idx)
        REG_NAMES_BASE:   names_base = value[ADDR_W-1:0];
        REG_NUMERIC_FONT: fonts[FONT_NUMERIC] = value[FONT_W-1:0];
        REG_UPPER_FONT:   fonts[FONT_UPPER] = value[FONT_W-1:0];
        REG_LOWER_FONT:   fonts[FONT_LOWER] = value[FONT_W-1:0];
        REG_SYMBOL_FONT:  fonts[FONT_SYMBOL] = value[FONT_W-1:0];
        default: ;
      endcase
    endfunction

    function void push_write(logic [ADDR_W-1:0] addr, logic [TILE_W-1:0] tile, logic last);
      out_req_t w;
      w.vram_addr  = addr;
      w.tile_index = tile;
      w.last       = last;
      pending_writes.push_back(w);
    endfunction

    function void draw_glyph(font_sel_e sel, logic [7:0] g);
      logic [TILE_W-1:0] first;
      logic [TILE_W-1:0] setw;
      logic [TILE_W-1:0] c;
      logic [TILE_W-1:0] base;
      logic [ADDR_W-1:0] a;
      shape_e            shape;
      first = fonts[sel][7:0];
      setw  = fonts[sel][15:8];
      shape = shape_e'(fonts[sel][17:16]);
      a     = cursor;
      case (shape)
        SHAPE_1X1: begin
          base = first + g;
          push_write(a, base, 1'b1);
          cursor = a + 14'd1;
        end
        SHAPE_1X2: begin
          base = first + g;
          push_write(a, base, 1'b0);
          push_write(ADDR_W'(a + ROW_TILES), TILE_W'(base + setw), 1'b1);
          cursor = a + 14'd1;
        end
        SHAPE_2X2: begin
          c    = g << 1;
          base = first + c;
          // glyphs past the first row of the set skip a tile row
          if (c > WIDE_OFFSET) base = base + WIDE_OFFSET;
          push_write(a, base, 1'b0);
          push_write(ADDR_W'(a + 1), TILE_W'(base + 1), 1'b0);
          push_write(ADDR_W'(a + ROW_TILES), TILE_W'(base + setw), 1'b0);
          push_write(ADDR_W'(a + ROW_TILES + 1), TILE_W'(base + setw + 1), 1'b1);
          cursor = a + 14'd2;
        end
        default: cursor = a + 14'd1;
      endcase
    endfunction

    function void add_char_writes(in_req_t r);
      logic [7:0] ch;
      ch = r.char_code;
      if (r.command == CMD_SET_CURSOR) begin
        cursor = ADDR_W'(names_base + r.row * ROW_TILES + r.column);
      end else if (ch == CH_SPACE) begin
        cursor = cursor + 14'd1;
      end else if (ch >= CH_DIG_FIRST && ch <= CH_DIG_LAST) begin
        draw_glyph(FONT_NUMERIC, ch - CH_DIG_FIRST);
      end else if (ch >= CH_UPP_FIRST && ch <= CH_UPP_LAST) begin
        draw_glyph(FONT_UPPER, ch - CH_UPP_FIRST);
      end else if (ch >= CH_LOW_FIRST && ch <= CH_LOW_LAST) begin
        draw_glyph(FONT_LOWER, ch - CH_LOW_FIRST);
      end else if (ch >= CH_SYM_FIRST && ch <= CH_SYM_LAST) begin
        draw_glyph(FONT_SYMBOL, ch - CH_SYM_FIRST);
      end
    endfunction

    task report(string msg);
      if (errors < 50) $display("%0t: mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_write(out_req_t got);
      out_req_t exp;
      if (pending_writes.size() == 0) begin
        report($sformatf("unexpected write addr %h tile %h", got.vram_addr, got.tile_index));
      end else begin
        exp = pending_writes.pop_front();
        if (got.vram_addr !== exp.vram_addr)
          report($sformatf("vram_addr %h, expected %h", got.vram_addr, exp.vram_addr));
        if (got.tile_index !== exp.tile_index)
          report($sformatf("tile_index %h, expected %h", got.tile_index, exp.tile_index));
        if (got.last !== exp.last)
          report($sformatf("last %b, expected %b", got.last, exp.last));
      end
    endtask
  endclass

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  in_req_t              in_req_i    = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_req_t             out_req_o;
  logic                 psel        = 1'b0;
  logic                 penable     = 1'b0;
  logic                 pwrite      = 1'b0;
  logic [PADDR_W-1:0]   paddr       = '0;
  logic [PDATA_W-1:0]   pwdata      = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  name_write_board tracker = new();

  int burst_left = 0;
  bit gaps_on    = 1'b1;
  int stall_run  = 0;
  int stall_mode = 0;
  int stall_tick = 0;

  text_to_tile_name_writer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #10 clk_i = ~clk_i;

  // receiver stall pattern, changing mode after each run of random length
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (stall_run == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_run  = $urandom_range(5, 40);
      end
      stall_run--;
      stall_tick++;
      case (stall_mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 1) == 0);
        2:       out_stall_i <= ($urandom_range(0, 3) == 0);
        default: out_stall_i <= (stall_tick % 3 == 0);
      endcase
    end
  end

  // outputs are stable mid-cycle; a write seen here is taken at the next edge
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) tracker.check_write(out_req_o);
  end

  task cfg_write(reg_idx_e idx, logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(idx * 4);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    while (!pready) @(negedge clk_i);
    @(posedge clk_i);
    tracker.set_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task send_req(in_req_t r);
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    tracker.add_char_writes(r);
    @(posedge clk_i);
  endtask

  task run_req(in_req_t r);
    send_req(r);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (gaps_on) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  // hold off the sender until every pending write has come out or the wait times out
  task wait_idle();
    int n;
    in_valid_i <= 1'b0;
    for (n = 0; n < 20000 && tracker.pending_writes.size() != 0; n++) @(posedge clk_i);
    if (tracker.pending_writes.size() != 0) begin
      tracker.report($sformatf("%0d writes never came", tracker.pending_writes.size()));
      tracker.pending_writes.delete();
    end
    repeat (20) @(posedge clk_i);
  endtask

  function automatic in_req_t cursor_req(logic [4:0] col, logic [4:0] row);
    in_req_t r;
    r           = in_req_t'(IN_REQ_W'($urandom));
    r.command   = CMD_SET_CURSOR;
    r.column    = col;
    r.row       = row;
    return r;
  endfunction

  function automatic in_req_t char_req(logic [7:0] ch);
    in_req_t r;
    r           = in_req_t'(IN_REQ_W'($urandom));
    r.command   = CMD_PRINT;
    r.char_code = ch;
    return r;
  endfunction

  function automatic in_req_t random_req();
    in_req_t r;
    int      pick;
    r    = in_req_t'(IN_REQ_W'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      r.command = CMD_SET_CURSOR;
      if ($urandom_range(0, 3) != 0) r.row = 5'($urandom_range(0, 23));
    end else begin
      r.command = CMD_PRINT;
      if (pick < 22) begin
        r.char_code = CH_SPACE;
      end else if (pick < 85) begin
        case ($urandom_range(0, 3))
          0:       r.char_code = 8'($urandom_range(CH_DIG_FIRST, CH_DIG_LAST));
          1:       r.char_code = 8'($urandom_range(CH_UPP_FIRST, CH_UPP_LAST));
          2:       r.char_code = 8'($urandom_range(CH_LOW_FIRST, CH_LOW_LAST));
          default: r.char_code = 8'($urandom_range(CH_SYM_FIRST, CH_SYM_LAST));
        endcase
      end else begin
        r.char_code = 8'($urandom_range(0, 255));
      end
    end
    return r;
  endfunction

  task load_config(int ph);
    logic [PDATA_W-1:0] v;
    reg_idx_e           idx;
    for (int i = 0; i < 5; i++) begin
      idx = reg_idx_e'(i);
      if (ph == 0) begin
        v = '0;
      end else if (ph == 1) begin
        // widest fields, one shape per font
        v = (idx == REG_NAMES_BASE) ? 32'h3fff : (32'h0000ffff | ((i - 1) << 16));
      end else begin
        v = $urandom;
        if (idx != REG_NAMES_BASE && $urandom_range(0, 1) == 0) v[17:16] = SHAPE_2X2;
      end
      cfg_write(idx, v);
    end
  endtask

  initial begin
    #4000000;
    $display("FAIL text_to_tile_name_writer");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: every font 1x1 from tile 0, table at its reset base
    run_req(cursor_req(5'd0, 5'd0));
    run_req(char_req("A"));
    run_req(char_req("9"));
    run_req(char_req(" "));
    run_req(char_req("z"));
    run_req(char_req("!"));
    run_req(char_req("/"));
    wait_idle();

    cfg_write(REG_NAMES_BASE, 32'h3fff);
    cfg_write(REG_NUMERIC_FONT, {14'd0, SHAPE_1X1, 8'h00, 8'hff});
    cfg_write(REG_UPPER_FONT, {14'd0, SHAPE_1X2, 8'hff, 8'h80});
    cfg_write(REG_LOWER_FONT, {14'd0, SHAPE_2X2, 8'h20, 8'h10});
    cfg_write(REG_SYMBOL_FONT, {14'd0, SHAPE_NONE, 8'h11, 8'h22});

    // row past the display and base at the top of the address space
    run_req(cursor_req(5'd31, 5'd31));
    run_req(char_req("0"));
    run_req(char_req("9"));
    run_req(char_req("A"));
    run_req(char_req("Z"));
    run_req(char_req("a"));
    run_req(char_req("q"));
    run_req(char_req("r"));
    run_req(char_req("z"));
    run_req(char_req(" "));
    run_req(char_req("~"));
    run_req(char_req(8'h00));
    run_req(char_req(8'hff));
    run_req(char_req("!"));
    run_req(char_req("/"));
    run_req(cursor_req(5'd0, 5'd0));
    run_req(char_req("b"));
    wait_idle();

    for (int ph = 0; ph < 7; ph++) begin
      gaps_on = (ph % 3 != 1);
      load_config(ph);
      repeat (51) run_req(random_req());
      wait_idle();
    end

    if (tracker.errors == 0) begin
      $display("PASS text_to_tile_name_writer");
    end else begin
      $display("FAIL text_to_tile_name_writer");
    end
    $finish;
  end

endmodule
